>>> sv/i8mma_pkg.sv
package i8mma_pkg;

  localparam int MAX_INNER   = 256;
  localparam int MAX_COLUMNS = 16;

  // index widths, kept at one bit minimum
  localparam int ROW_W = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  // widths that can hold the counts themselves
  localparam int LEN_W = $clog2(MAX_INNER + 1);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  // register select, taken from paddr[2]
  localparam logic REG_INNER_LENGTH = 1'b0;
  localparam logic REG_COLUMNS_USED = 1'b1;

  // broadcast control from the sequencer to every column cell
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] raddr;
    logic             mul_en;
    logic signed [7:0] act;
    logic             acc_en;
    logic             shift;
    logic             clear;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_LOAD,
    ST_CONV
  } mma_state_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_NORM,
    CV_DONE
  } cv_state_t;

endpackage

>>> sv/i8mma_cell.sv
module i8mma_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  i8mma_pkg::cell_ctl_t          ctl,
  input  logic                          we,
  input  logic [i8mma_pkg::ROW_W-1:0]   waddr,
  input  logic signed [7:0]             wdata,
  input  logic signed [31:0]            shift_in,
  output logic signed [31:0]            acc
);
  import i8mma_pkg::*;

  logic signed [7:0]  mem [MAX_INNER];
  logic signed [7:0]  wq;
  logic signed [15:0] prod;

  // weight column slice, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      wq <= mem[ctl.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= $signed(ctl.act) * $signed(wq);
    end
  end

  // clear wins over drain shift, shift over accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.shift) begin
      acc <= shift_in;
    end else if (ctl.acc_en) begin
      acc <= acc + {{16{prod[15]}}, prod};
    end
  end

endmodule

>>> sv/i8mma_i2f.sv
module i8mma_i2f (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] din,
  output logic        done,
  output logic [31:0] result
);
  import i8mma_pkg::*;

  cv_state_t   state, state_next;
  logic        sign;
  logic [31:0] mag;
  logic [4:0]  p;

  logic        round_up;
  logic [24:0] mant_rnd;
  logic [7:0]  exp_field;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CV_IDLE: if (start) state_next = CV_NORM;
      CV_NORM: if (mag == '0 || mag[31]) state_next = CV_DONE;
      CV_DONE: if (start) state_next = CV_NORM;
      default: state_next = CV_IDLE;
    endcase
  end

  assign done = (state == CV_DONE);

  // round to nearest even on the bits below the 24-bit significand
  assign round_up  = mag[7] && ((|mag[6:0]) || mag[8]);
  assign mant_rnd  = {1'b0, 1'b1, mag[30:8]} + {24'd0, round_up};
  assign exp_field = 8'd127 + {3'd0, p} + {7'd0, mant_rnd[24]};

  // normalize: byte steps while the top byte is empty, then single bits
  always_ff @(posedge clk) begin
    if (start) begin
      sign <= din[31];
      mag  <= din[31] ? (32'd0 - din) : din;
      p    <= 5'd31;
    end else if (state == CV_NORM) begin
      if (mag == '0) begin
        result <= '0;
      end else if (mag[31]) begin
        result <= {sign, exp_field, mant_rnd[24] ? 23'd0 : mant_rnd[22:0]};
      end else if (mag[31:24] == 8'd0) begin
        mag <= {mag[23:0], 8'd0};
        p   <= p - 5'd8;
      end else begin
        mag <= {mag[30:0], 1'b0};
        p   <= p - 5'd1;
      end
    end
  end

endmodule

>>> sv/int8_matrix_multiply_accumulate.sv
// Pipeline: an accepted element passes the weight read (wq, act_s1), the product register, then the accumulators.
// Throughput: one weight load or one element per cycle while in_ready is high (only in ST_RUN, not during row end).
// Row end: a flush until the element pipeline is empty, then per column a load state and the iterative
// int-to-fp32 normalizer (byte then bit shifts), results drain out of column cell 0.
// Reset (rst, synchronous): accumulators and position zero, inner_length 256,
// columns_used 16; weight memories are not cleared and hold garbage until written.
module int8_matrix_multiply_accumulate (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [7:0]         weight_row,
  input  logic [3:0]         weight_column,
  input  logic signed [7:0]  value,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         column_index,
  output logic signed [31:0] sum_integer,
  output logic [31:0]        sum_float_bits,
  output logic               last
);
  import i8mma_pkg::*;

  // ---------------- configuration registers ----------------
  logic [8:0] inner_length;
  logic [4:0] columns_used;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_length <= 9'd256;
      columns_used <= 5'd16;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_INNER_LENGTH: inner_length <= pwdata[8:0];
        REG_COLUMNS_USED: columns_used <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INNER_LENGTH: prdata = {23'd0, inner_length};
      REG_COLUMNS_USED: prdata = {27'd0, columns_used};
      default:          prdata = '0;
    endcase
  end

  // clamped lengths: zero acts as one, oversize acts as the maximum
  logic [LEN_W-1:0] len_eff;
  logic [CNT_W-1:0] cols_eff;

  always_comb begin
    if (inner_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(inner_length) > MAX_INNER) begin
      len_eff = LEN_W'(MAX_INNER);
    end else begin
      len_eff = LEN_W'(inner_length);
    end
    if (columns_used == '0) begin
      cols_eff = CNT_W'(1);
    end else if (32'(columns_used) > MAX_COLUMNS) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_W'(columns_used);
    end
  end

  // ---------------- input acceptance and element pipeline ----------------
  mma_state_t       state, state_next;
  logic             accept, el, ld, el_last, wr_ok;
  logic [ROW_W-1:0] pos;
  logic             s1_valid, s2_valid;
  logic signed [7:0] act_s1;

  assign in_ready = (state == ST_RUN);
  assign accept   = in_valid && in_ready;
  assign el       = accept && action;
  assign ld       = accept && !action;
  assign el_last  = el && ((32'(pos) + 1) >= 32'(len_eff));
  // loads outside the store are dropped
  assign wr_ok    = (32'(weight_row) < MAX_INNER) && (32'(weight_column) < MAX_COLUMNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (el_last) begin
        pos <= '0;
      end else if (el) begin
        pos <= pos + ROW_W'(1);
      end
      s1_valid <= el;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (el) begin
      act_s1 <= value;
    end
  end

  // ---------------- row-end drain sequencer ----------------
  logic [COL_W-1:0] drain_col, drain_col_next;
  logic             col_last, out_free, out_load, conv_start, conv_done;
  logic             do_shift, do_clear;
  logic [31:0]      conv_result;
  logic signed [31:0] acc_chain [MAX_COLUMNS+1];

  assign col_last = (32'(drain_col) + 1) == 32'(cols_eff);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      drain_col <= '0;
    end else begin
      state     <= state_next;
      drain_col <= drain_col_next;
    end
  end

  always_comb begin
    state_next     = state;
    drain_col_next = drain_col;
    conv_start     = 1'b0;
    out_load       = 1'b0;
    do_shift       = 1'b0;
    do_clear       = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (el_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        // wait for the final element to land in the accumulators
        if (!s1_valid && !s2_valid) begin
          state_next     = ST_LOAD;
          drain_col_next = '0;
        end
      end
      ST_LOAD: begin
        conv_start = 1'b1;
        state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done && out_free) begin
          out_load = 1'b1;
          if (col_last) begin
            do_clear   = 1'b1;
            state_next = ST_RUN;
          end else begin
            do_shift       = 1'b1;
            drain_col_next = drain_col + COL_W'(1);
            state_next     = ST_LOAD;
          end
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // ---------------- column cell chain ----------------
  cell_ctl_t ctl;

  always_comb begin
    ctl.rd_en  = el;
    ctl.raddr  = pos;
    ctl.mul_en = s1_valid;
    ctl.act    = act_s1;
    ctl.acc_en = s2_valid;
    ctl.shift  = do_shift;
    ctl.clear  = do_clear;
  end

  // past the end of the chain shifts in zero
  assign acc_chain[MAX_COLUMNS] = '0;

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
    i8mma_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .we       (ld && wr_ok && (32'(weight_column) == c)),
      .waddr    (ROW_W'(weight_row)),
      .wdata    (value),
      .shift_in (acc_chain[c+1]),
      .acc      (acc_chain[c])
    );
  end

  i8mma_i2f u_i2f (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .din    (acc_chain[0]),
    .done   (conv_done),
    .result (conv_result)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      column_index   <= 4'(drain_col);
      sum_integer    <= acc_chain[0];
      sum_float_bits <= conv_result;
      last           <= col_last;
    end
  end

  // ---------------- checks ----------------
  a_drain_after_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (!s1_valid && !s2_valid))
    else $error("drain started with elements still in the pipeline");

  a_row_end: assert property (@(posedge clk) disable iff (rst)
    el_last |=> (state == ST_FLUSH && pos == '0))
    else $error("row end did not enter flush with position cleared");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_load && col_last) |=> (state == ST_RUN && out_valid && last))
    else $error("final column did not close the row");

  a_no_accept_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV || state == ST_LOAD) |-> !in_ready)
    else $error("input taken during drain");

endmodule
